>>> rtl/ecs_pkg.sv
// elevator call scheduler package: state codes, command codes, scan codes,
// controller/datapath interface structs and reset constants; no dependencies
package ecs_pkg;

    localparam int DEF_NUM_FLOORS      = 5;
    localparam int CMD_W               = 2;
    localparam int FLOOR_W             = 3;
    localparam int TICKS_W             = 16;
    localparam int DRIVE_W             = 2;
    localparam int APB_AW              = 3;
    localparam int APB_DW              = 32;
    localparam logic [TICKS_W-1:0] DEF_TICKS_PER_FLOOR = 16'd30;

    // request / tick codes on the command field
    typedef enum logic [CMD_W-1:0] {
        CMD_CAR_CALL  = 2'd0,
        CMD_HALL_UP   = 2'd1,
        CMD_HALL_DOWN = 2'd2,
        CMD_TICK      = 2'd3
    } t_cmd;

    // motor drive codes
    typedef enum logic [DRIVE_W-1:0] {
        DRIVE_IDLE = 2'd0,
        DRIVE_UP   = 2'd1,
        DRIVE_DOWN = 2'd2
    } t_drive;

    // register indexes
    typedef enum logic [0:0] {
        REG_TICKS_PER_FLOOR = 1'b0
    } t_reg_idx;

    // operations of the shared floor scan unit
    typedef enum logic [1:0] {
        SCAN_UP     = 2'd0,
        SCAN_DOWN   = 2'd1,
        PICK_ABOVE  = 2'd2,
        PICK_BELOW  = 2'd3
    } t_scan_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN_UP,
        S_SCAN_DN,
        S_PICK_ABOVE,
        S_PICK_BELOW,
        S_RESCAN_UP,
        S_RESCAN_DN,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     apply;
        logic     scan_en;
        t_scan_op scan_op;
        logic     decide;
    } t_dp_cmd;

    typedef struct packed {
        logic moving;
    } t_dp_status;

endpackage

>>> rtl/ecs_ctrl.sv
// ecs sequencer: steps an item through apply, scans and, for a standing car, decision
// depends on ecs_pkg
module ecs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ecs_pkg::t_dp_status i_status,
    output ecs_pkg::t_dp_cmd   o_cmd,
    output logic               busy,
    output logic               o_valid
);

    ecs_pkg::t_state r_state;
    ecs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ecs_pkg::S_IDLE:       if (start) n_state = ecs_pkg::S_APPLY;
            ecs_pkg::S_APPLY:      n_state = ecs_pkg::S_SCAN_UP;
            ecs_pkg::S_SCAN_UP:    n_state = ecs_pkg::S_SCAN_DN;
            ecs_pkg::S_SCAN_DN:    n_state = ecs_pkg::S_PICK_ABOVE;
            ecs_pkg::S_PICK_ABOVE: n_state = ecs_pkg::S_PICK_BELOW;
            ecs_pkg::S_PICK_BELOW: begin
                // a moving car keeps its first scan results
                n_state = i_status.moving ? ecs_pkg::S_DONE : ecs_pkg::S_RESCAN_UP;
            end
            ecs_pkg::S_RESCAN_UP:  n_state = ecs_pkg::S_RESCAN_DN;
            ecs_pkg::S_RESCAN_DN:  n_state = ecs_pkg::S_DECIDE;
            ecs_pkg::S_DECIDE:     n_state = ecs_pkg::S_DONE;
            ecs_pkg::S_DONE:       n_state = ecs_pkg::S_IDLE;
            default:               n_state = ecs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.scan_op = ecs_pkg::SCAN_UP;
        busy          = 1'b1;
        o_valid       = 1'b0;
        case (r_state)
            ecs_pkg::S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ecs_pkg::S_APPLY:      o_cmd.apply = 1'b1;
            ecs_pkg::S_SCAN_UP,
            ecs_pkg::S_RESCAN_UP: begin
                o_cmd.scan_en = 1'b1;
                o_cmd.scan_op = ecs_pkg::SCAN_UP;
            end
            ecs_pkg::S_SCAN_DN,
            ecs_pkg::S_RESCAN_DN: begin
                o_cmd.scan_en = 1'b1;
                o_cmd.scan_op = ecs_pkg::SCAN_DOWN;
            end
            ecs_pkg::S_PICK_ABOVE: begin
                o_cmd.scan_en = 1'b1;
                o_cmd.scan_op = ecs_pkg::PICK_ABOVE;
            end
            ecs_pkg::S_PICK_BELOW: begin
                o_cmd.scan_en = 1'b1;
                o_cmd.scan_op = ecs_pkg::PICK_BELOW;
            end
            ecs_pkg::S_DECIDE:     o_cmd.decide = 1'b1;
            ecs_pkg::S_DONE:       o_valid = 1'b1;
            default:               busy = 1'b1;
        endcase
    end

endmodule

>>> rtl/ecs_datapath.sv
// elevator call scheduler datapath: call marks, car position, travel timer
// and the shared floor scan unit; depends on ecs_pkg
module ecs_datapath #(
    parameter int NUM_FLOORS = ecs_pkg::DEF_NUM_FLOORS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ecs_pkg::t_dp_cmd              i_cmd,
    output ecs_pkg::t_dp_status           o_status,
    input  logic [ecs_pkg::CMD_W-1:0]     i_command,
    input  logic [ecs_pkg::FLOOR_W-1:0]   i_floor,
    input  logic [ecs_pkg::TICKS_W-1:0]   i_ticks_per_floor,
    output logic [ecs_pkg::FLOOR_W-1:0]   o_car_floor,
    output logic [ecs_pkg::DRIVE_W-1:0]   o_motor_drive,
    output logic                          o_arrived_served,
    output logic                          o_calls_above,
    output logic                          o_calls_below
);

    localparam int FW = $clog2(NUM_FLOORS);
    localparam int TW = ecs_pkg::TICKS_W;

    logic [NUM_FLOORS-1:0] r_car, n_car;
    logic [NUM_FLOORS-1:0] r_up, n_up;
    logic [NUM_FLOORS-1:0] r_dn, n_dn;
    logic [FW-1:0]         r_floor, n_floor;
    logic                  r_heading_up, n_heading_up;
    logic                  r_moving, n_moving;
    logic [TW-1:0]         r_ticks, n_ticks;
    logic                  r_served, n_served;
    logic                  r_above, n_above;
    logic                  r_below, n_below;
    logic [ecs_pkg::CMD_W-1:0]   r_cmd;
    logic [ecs_pkg::FLOOR_W-1:0] r_req_floor;

    logic                  w_req_ok;
    logic [FW-1:0]         w_req_idx;
    logic [TW:0]           w_tick_sum;
    logic                  w_arrive;
    logic [FW-1:0]         w_stop_floor;

    // scan unit
    logic [NUM_FLOORS-1:0] w_above_m, w_below_m, w_atbelow_m;
    logic [NUM_FLOORS-1:0] w_cand;
    logic                  w_low_first;
    logic                  w_hit;
    logic [FW-1:0]         w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car        <= '0;
            r_up         <= '0;
            r_dn         <= '0;
            r_floor      <= '0;
            r_heading_up <= 1'b1;
            r_moving     <= 1'b0;
            r_ticks      <= '0;
            r_served     <= 1'b0;
            r_above      <= 1'b0;
            r_below      <= 1'b0;
        end else begin
            r_car        <= n_car;
            r_up         <= n_up;
            r_dn         <= n_dn;
            r_floor      <= n_floor;
            r_heading_up <= n_heading_up;
            r_moving     <= n_moving;
            r_ticks      <= n_ticks;
            r_served     <= n_served;
            r_above      <= n_above;
            r_below      <= n_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd       <= i_command;
            r_req_floor <= i_floor;
        end
    end

    assign w_req_ok   = int'(r_req_floor) < NUM_FLOORS;
    assign w_req_idx  = FW'(r_req_floor);
    assign w_tick_sum = {1'b0, r_ticks} + (TW+1)'(1);
    assign w_arrive   = w_tick_sum >= {1'b0, i_ticks_per_floor};

    // next floor with saturation at both ends
    always_comb begin
        w_stop_floor = r_floor;
        if (r_heading_up) begin
            if (int'(r_floor) < NUM_FLOORS - 1) w_stop_floor = r_floor + FW'(1);
        end else begin
            if (r_floor != '0) w_stop_floor = r_floor - FW'(1);
        end
    end

    always_comb begin
        for (int f = 0; f < NUM_FLOORS; f++) begin
            w_above_m[f]   = f > int'(r_floor);
            w_below_m[f]   = f < int'(r_floor);
            w_atbelow_m[f] = f <= int'(r_floor);
        end
        case (i_cmd.scan_op)
            ecs_pkg::SCAN_UP: begin
                w_cand      = (r_car | r_up) & w_above_m;
                w_low_first = 1'b1;
            end
            ecs_pkg::SCAN_DOWN: begin
                w_cand      = (r_car | r_dn) & w_below_m;
                w_low_first = 1'b0;
            end
            ecs_pkg::PICK_ABOVE: begin
                w_cand      = r_dn & w_above_m;
                w_low_first = 1'b1;
            end
            ecs_pkg::PICK_BELOW: begin
                w_cand      = r_up & w_atbelow_m;
                w_low_first = 1'b0;
            end
            default: begin
                w_cand      = '0;
                w_low_first = 1'b1;
            end
        endcase
        // nearest marked floor in the scan direction
        w_idx = '0;
        if (w_low_first) begin
            for (int f = NUM_FLOORS - 1; f >= 0; f--) begin
                if (w_cand[f]) w_idx = FW'(f);
            end
        end else begin
            for (int f = 0; f < NUM_FLOORS; f++) begin
                if (w_cand[f]) w_idx = FW'(f);
            end
        end
        w_hit = |w_cand;
    end

    always_comb begin
        n_car        = r_car;
        n_up         = r_up;
        n_dn         = r_dn;
        n_floor      = r_floor;
        n_heading_up = r_heading_up;
        n_moving     = r_moving;
        n_ticks      = r_ticks;
        n_served     = r_served;
        n_above      = r_above;
        n_below      = r_below;

        if (i_cmd.apply) begin
            n_served = 1'b0;
            if (r_cmd == ecs_pkg::CMD_TICK) begin
                if (r_moving) begin
                    n_ticks = w_tick_sum[TW-1:0];
                    if (w_arrive) begin
                        n_ticks  = '0;
                        n_moving = 1'b0;
                        n_floor  = w_stop_floor;
                        if (r_car[w_stop_floor]) begin
                            n_served               = 1'b1;
                            n_car[w_stop_floor]    = 1'b0;
                            n_up[w_stop_floor]     = 1'b0;
                            n_dn[w_stop_floor]     = 1'b0;
                        end
                    end
                end
            end else if (w_req_ok) begin
                case (r_cmd)
                    ecs_pkg::CMD_CAR_CALL: begin
                        if (w_req_idx != r_floor) n_car[w_req_idx] = 1'b1;
                    end
                    ecs_pkg::CMD_HALL_UP:   n_up[w_req_idx] = 1'b1;
                    default:                n_dn[w_req_idx] = 1'b1;
                endcase
            end
        end

        if (i_cmd.scan_en) begin
            if (w_hit) n_car[w_idx] = 1'b1;
            if (i_cmd.scan_op == ecs_pkg::SCAN_UP)   n_above = w_hit;
            if (i_cmd.scan_op == ecs_pkg::SCAN_DOWN) n_below = w_hit;
        end

        if (i_cmd.decide && !r_moving) begin
            if (r_heading_up ? (r_above || r_below) : (r_above || r_below)) begin
                n_moving     = 1'b1;
                n_ticks      = '0;
                n_heading_up = r_heading_up ? r_above : !r_below;
            end
        end
    end

    assign o_status.moving  = r_moving;
    assign o_car_floor      = ecs_pkg::FLOOR_W'(r_floor);
    assign o_motor_drive    = !r_moving     ? ecs_pkg::DRIVE_IDLE :
                              r_heading_up  ? ecs_pkg::DRIVE_UP : ecs_pkg::DRIVE_DOWN;
    assign o_arrived_served = r_served;
    assign o_calls_above    = r_above;
    assign o_calls_below    = r_below;

endmodule

>>> rtl/elevator_call_scheduler_core.sv
// elevator call scheduler top level: apb register, sequencer and datapath
// depends on ecs_pkg, ecs_ctrl, ecs_datapath
//
// usage:
//  - an item (command, floor) is taken at a clock edge with start high and busy low;
//    command is a car call, hall up call, hall down call or a timer tick
//  - each item gives exactly one result on o_car_floor, o_motor_drive,
//    o_arrived_served, o_calls_above and o_calls_below, shown for one cycle
//    with o_valid high; the receiver cannot stall, so nothing is held back
//  - per item: one apply step, four scans on the shared scan unit, and, when the
//    car stands, two rescans plus a decision step, then one result cycle;
//    busy drops after the result cycle, and only then is the next item taken,
//    so items never overlap
//  - the scan unit (one priority search over the floor marks a cycle) sets the pace
//  - ticks_per_floor sits at byte address 0 of the apb port; write it only
//    while busy is low; pready is always high and reads return the value
//  - reset (synchronous, active low) clears all calls, parks the car at floor 0
//    heading up and stopped, and loads ticks_per_floor with 30
module elevator_call_scheduler_core #(
    parameter int NUM_FLOORS = ecs_pkg::DEF_NUM_FLOORS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  logic [ecs_pkg::CMD_W-1:0]     i_command,
    input  logic [ecs_pkg::FLOOR_W-1:0]   i_floor,
    // result channel
    output logic                          o_valid,
    output logic [ecs_pkg::FLOOR_W-1:0]   o_car_floor,
    output logic [ecs_pkg::DRIVE_W-1:0]   o_motor_drive,
    output logic                          o_arrived_served,
    output logic                          o_calls_above,
    output logic                          o_calls_below,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecs_pkg::APB_AW-1:0]    paddr,
    input  logic [ecs_pkg::APB_DW-1:0]    pwdata,
    output logic [ecs_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [ecs_pkg::TICKS_W-1:0] r_ticks_per_floor;
    ecs_pkg::t_reg_idx           w_reg_idx;
    logic                        w_cfg_wr;
    ecs_pkg::t_dp_cmd            w_cmd;
    ecs_pkg::t_dp_status         w_status;

    // register index is the word address
    assign w_reg_idx = ecs_pkg::t_reg_idx'(paddr[2]);
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_floor <= ecs_pkg::DEF_TICKS_PER_FLOOR;
        end else if (w_cfg_wr && w_reg_idx == ecs_pkg::REG_TICKS_PER_FLOOR) begin
            r_ticks_per_floor <= pwdata[ecs_pkg::TICKS_W-1:0];
        end
    end

    // unused word address reads as zero
    always_comb begin
        prdata = '0;
        if (w_reg_idx == ecs_pkg::REG_TICKS_PER_FLOOR) begin
            prdata = ecs_pkg::APB_DW'(r_ticks_per_floor);
        end
    end

    // item sequencer
    ecs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    // call marks, car state and scan unit
    ecs_datapath #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_command         (i_command),
        .i_floor           (i_floor),
        .i_ticks_per_floor (r_ticks_per_floor),
        .o_car_floor       (o_car_floor),
        .o_motor_drive     (o_motor_drive),
        .o_arrived_served  (o_arrived_served),
        .o_calls_above     (o_calls_above),
        .o_calls_below     (o_calls_below)
    );

`ifndef NO_ASSERTIONS
    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // the result cycle is the last busy cycle
    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy still high after result");

    // a result is only shown while an item is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside an item");

    // car stays within the building and never reports an undefined drive
    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_car_floor) < NUM_FLOORS && o_motor_drive != 2'd3))
        else $error("car floor or motor drive out of range");
`endif

endmodule

>>> tb/tb_elevator_call_scheduler_core.sv
// self-checking testbench for elevator_call_scheduler_core: directed table, then random
// phases at several travel times; depends on ecs_pkg and the elevator_call_scheduler_core rtl
`timescale 1ns / 100ps

module tb_elevator_call_scheduler_core;

    localparam int NUM_FLOORS  = ecs_pkg::DEF_NUM_FLOORS;
    localparam int FLOOR_W     = ecs_pkg::FLOOR_W;
    localparam int TICKS_W     = ecs_pkg::TICKS_W;
    localparam int CMD_W       = ecs_pkg::CMD_W;
    localparam int DRIVE_W     = ecs_pkg::DRIVE_W;
    localparam int APB_AW      = ecs_pkg::APB_AW;
    localparam int APB_DW      = ecs_pkg::APB_DW;
    localparam int ITEMS_PHASE = 240;
    localparam int MAX_GAP     = 12;
    localparam int REPORT_MAX  = 10;

    // one result item as the block shows it
    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        ecs_pkg::t_drive    drive;
        logic               served;
        logic               above;
        logic               below;
    } t_car_report;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // one row of the directed table: an item or a travel time write
    typedef struct packed {
        t_row_kind          kind;
        ecs_pkg::t_cmd      cmd;
        logic [FLOOR_W-1:0] flr;
        logic [TICKS_W-1:0] ticks;
        logic               typed;
        t_car_report        want;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_command;
    logic [FLOOR_W-1:0]  i_floor;
    logic                o_valid;
    logic [FLOOR_W-1:0]  o_car_floor;
    logic [DRIVE_W-1:0]  o_motor_drive;
    logic                o_arrived_served;
    logic                o_calls_above;
    logic                o_calls_below;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // shadow of the scheduler state, advanced once per accepted item
    logic [NUM_FLOORS-1:0] car_mark;
    logic [NUM_FLOORS-1:0] hall_up_mark;
    logic [NUM_FLOORS-1:0] hall_down_mark;
    int unsigned           car_pos;
    logic                  heading_up;
    logic                  in_motion;
    int unsigned           travel_ticks;
    logic [TICKS_W-1:0]    travel_setting;

    t_car_report pending_reports[$];
    t_stim_row   plan_rows[$];
    int          fault_count;
    logic        steady_run;

    elevator_call_scheduler_core #(
        .NUM_FLOORS (NUM_FLOORS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_floor          (i_floor),
        .o_valid          (o_valid),
        .o_car_floor      (o_car_floor),
        .o_motor_drive    (o_motor_drive),
        .o_arrived_served (o_arrived_served),
        .o_calls_above    (o_calls_above),
        .o_calls_below    (o_calls_below),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // up sweep: the nearest floor above with a car call or a hall up call wins;
    // a hall up call there is taken on as a car call
    function automatic logic sweep_above();
        for (int f = int'(car_pos) + 1; f < NUM_FLOORS; f++) begin
            if (car_mark[f]) return 1'b1;
            if (hall_up_mark[f]) begin
                car_mark[f] = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // down sweep: mirror image with hall down calls, current floor excluded
    function automatic logic sweep_below();
        for (int f = int'(car_pos) - 1; f >= 0; f--) begin
            if (car_mark[f]) return 1'b1;
            if (hall_down_mark[f]) begin
                car_mark[f] = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void claim_down_call_above();
        for (int f = int'(car_pos) + 1; f < NUM_FLOORS; f++) begin
            if (hall_down_mark[f]) begin
                car_mark[f] = 1'b1;
                return;
            end
        end
    endfunction

    // note: this one includes the current floor
    function automatic void claim_up_call_at_or_below();
        for (int f = int'(car_pos); f >= 0; f--) begin
            if (hall_up_mark[f]) begin
                car_mark[f] = 1'b1;
                return;
            end
        end
    endfunction

    function automatic void begin_travel(logic go_up);
        heading_up   = go_up;
        in_motion    = 1'b1;
        travel_ticks = 0;
    endfunction

    // next report of the car for one item; updates the shadow state
    function automatic t_car_report schedule_step(ecs_pkg::t_cmd cmd,
                                                  logic [FLOOR_W-1:0] flr);
        t_car_report rep;
        logic        served;
        logic        above;
        logic        below;
        served = 1'b0;
        if (cmd == ecs_pkg::CMD_TICK) begin
            // ticks only count while the car travels
            if (in_motion) begin
                travel_ticks++;
                // a lowered travel time can already be passed: stop right away
                if (travel_ticks >= travel_setting) begin
                    travel_ticks = 0;
                    in_motion    = 1'b0;
                    if (heading_up) begin
                        if (car_pos + 1 < NUM_FLOORS) car_pos++;
                    end else begin
                        if (car_pos > 0) car_pos--;
                    end
                    // stop without a car call here leaves every mark alone
                    if (car_mark[car_pos]) begin
                        served                  = 1'b1;
                        car_mark[car_pos]       = 1'b0;
                        hall_up_mark[car_pos]   = 1'b0;
                        hall_down_mark[car_pos] = 1'b0;
                    end
                end
            end
        end else if (flr < NUM_FLOORS) begin
            case (cmd)
                ecs_pkg::CMD_CAR_CALL: begin
                    if (flr != car_pos) car_mark[flr] = 1'b1;
                end
                ecs_pkg::CMD_HALL_UP: begin
                    hall_up_mark[flr] = 1'b1;
                end
                default: begin
                    hall_down_mark[flr] = 1'b1;
                end
            endcase
        end
        above = sweep_above();
        below = sweep_below();
        claim_down_call_above();
        claim_up_call_at_or_below();
        // a standing car rescans and picks its next heading, keeping the old one first
        if (!in_motion) begin
            above = sweep_above();
            below = sweep_below();
            if (heading_up) begin
                if (above) begin_travel(1'b1);
                else if (below) begin_travel(1'b0);
            end else begin
                if (below) begin_travel(1'b0);
                else if (above) begin_travel(1'b1);
            end
        end
        rep.car_floor = FLOOR_W'(car_pos);
        rep.drive     = !in_motion ? ecs_pkg::DRIVE_IDLE :
                        (heading_up ? ecs_pkg::DRIVE_UP : ecs_pkg::DRIVE_DOWN);
        rep.served    = served;
        rep.above     = above;
        rep.below     = below;
        return rep;
    endfunction

    task automatic add_row(t_row_kind kind, ecs_pkg::t_cmd cmd, logic [FLOOR_W-1:0] flr,
                           logic [TICKS_W-1:0] ticks, logic typed,
                           logic [FLOOR_W-1:0] e_floor, ecs_pkg::t_drive e_drive,
                           logic e_served, logic e_above, logic e_below);
        t_stim_row row;
        row.kind           = kind;
        row.cmd            = cmd;
        row.flr            = flr;
        row.ticks          = ticks;
        row.typed          = typed;
        row.want.car_floor = e_floor;
        row.want.drive     = e_drive;
        row.want.served    = e_served;
        row.want.above     = e_above;
        row.want.below     = e_below;
        plan_rows.push_back(row);
    endtask

    // present one item after a random gap and wait for the block to take it;
    // entered and left at a falling edge, start stays high when no gap follows
    task automatic issue_request(ecs_pkg::t_cmd cmd, logic [FLOOR_W-1:0] flr, logic typed,
                                 t_car_report want);
        int          gap;
        t_car_report guess;
        if ($urandom_range(0, 49) == 0) steady_run = !steady_run;
        gap = steady_run ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_floor   <= flr;
        do @(posedge i_clk); while (busy);
        guess = schedule_step(cmd, flr);
        pending_reports.push_back(typed ? want : guess);
        @(negedge i_clk);
    endtask

    // change the travel time once the block is quiet, then read it back
    task automatic program_travel_time(logic [TICKS_W-1:0] ticks);
        logic [APB_DW-1:0] readback;
        start <= 1'b0;
        while (pending_reports.size() != 0 || busy) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        // setup phase, upper data bits are noise the register must drop
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'(4 * int'(ecs_pkg::REG_TICKS_PER_FLOOR));
        pwdata  <= {16'($urandom_range(0, 65535)), ticks};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        travel_setting = ticks;
        // back-to-back read of the same register
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        if (readback !== APB_DW'(ticks)) begin
            if (fault_count < REPORT_MAX)
                $display("travel time readback: expected %0d got %0d", ticks, readback);
            fault_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result checker: every strobe must match the oldest pending report
    always @(posedge i_clk) begin
        t_car_report got;
        t_car_report want;
        if (i_rst_n && o_valid) begin
            got.car_floor = o_car_floor;
            got.drive     = ecs_pkg::t_drive'(o_motor_drive);
            got.served    = o_arrived_served;
            got.above     = o_calls_above;
            got.below     = o_calls_below;
            if (pending_reports.size() == 0) begin
                if (fault_count < REPORT_MAX)
                    $display("result with no item pending: floor %0d drive %0d", got.car_floor,
                             got.drive);
                fault_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got.car_floor !== want.car_floor || got.drive !== want.drive ||
                    got.served !== want.served || got.above !== want.above ||
                    got.below !== want.below) begin
                    if (fault_count < REPORT_MAX)
                        $display("report mismatch: exp fl %0d dr %0d sv %0d ab %0d be %0d, %s",
                                 want.car_floor, want.drive, want.served, want.above,
                                 want.below,
                                 $sformatf("got fl %0d dr %0d sv %0d ab %0d be %0d",
                                           got.car_floor, got.drive, got.served, got.above,
                                           got.below));
                    fault_count++;
                end
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("elevator_call_scheduler_core verification failed");
        $finish;
    end

    initial begin
        t_car_report        none;
        ecs_pkg::t_cmd      cmd;
        logic [FLOOR_W-1:0] flr;
        int                 pick;
        int                 counted;
        logic [TICKS_W-1:0] phase_ticks[$];

        // everything known from time zero, reset held low first
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_command = '0;
        i_floor   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        none      = '0;
        fault_count    = 0;
        steady_run     = 1'b0;
        car_mark       = '0;
        hall_up_mark   = '0;
        hall_down_mark = '0;
        car_pos        = 0;
        heading_up     = 1'b1;
        in_motion      = 1'b0;
        travel_ticks   = 0;
        travel_setting = ecs_pkg::DEF_TICKS_PER_FLOOR;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table; typed reports only where they are obvious
        // idle tick, car call at the car, out-of-range floors: nothing happens
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd0, '0, 1'b1, 3'd0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_CAR_CALL, 3'd0, '0, 1'b1, 3'd0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_UP, 3'd7, '0, 1'b1, 3'd0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd5, '0, 1'b1, 3'd0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        // car call at the top floor starts the car upward
        add_row(ROW_ITEM, ecs_pkg::CMD_CAR_CALL, 3'd4, '0, 1'b1, 3'd0, ecs_pkg::DRIVE_UP,
                1'b0, 1'b1, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd0, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd7, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd2, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        // travel time dropped below the count already run: stop on the next tick,
        // at a floor that holds no car call
        add_row(ROW_CFG, ecs_pkg::CMD_TICK, 3'd0, 16'd2, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd0, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_DOWN, 3'd2, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_UP, 3'd3, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd1, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_TICK, 3'd6, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_CAR_CALL, 3'd0, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_DOWN, 3'd4, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_UP, 3'd6, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_DOWN, 3'd5, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        add_row(ROW_ITEM, ecs_pkg::CMD_HALL_UP, 3'd1, '0, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        // shortest travel time: one tick per floor
        add_row(ROW_CFG, ecs_pkg::CMD_TICK, 3'd0, 16'd1, 1'b0, '0, ecs_pkg::DRIVE_IDLE,
                1'b0, 1'b0, 1'b0);
        for (int k = 0; k < 6; k++)
            add_row(ROW_ITEM, ecs_pkg::CMD_TICK, FLOOR_W'(k + 2), '0, 1'b0, '0,
                    ecs_pkg::DRIVE_IDLE, 1'b0, 1'b0, 1'b0);

        foreach (plan_rows[r]) begin
            if (plan_rows[r].kind == ROW_CFG)
                program_travel_time(plan_rows[r].ticks);
            else
                issue_request(plan_rows[r].cmd, plan_rows[r].flr, plan_rows[r].typed,
                              plan_rows[r].want);
        end

        // random phases over several travel times, extremes and zero among them
        phase_ticks = '{16'd3, 16'd0, 16'd65535, 16'd2, 16'd30, 16'd1, 16'd7,
                        TICKS_W'($urandom_range(1, 12))};
        foreach (phase_ticks[p]) begin
            program_travel_time(phase_ticks[p]);
            counted = 0;
            while (counted < ITEMS_PHASE) begin
                // ticks dominate so the car actually sweeps between calls
                pick = $urandom_range(0, 99);
                if (pick < 45)      cmd = ecs_pkg::CMD_TICK;
                else if (pick < 65) cmd = ecs_pkg::CMD_CAR_CALL;
                else if (pick < 83) cmd = ecs_pkg::CMD_HALL_UP;
                else                cmd = ecs_pkg::CMD_HALL_DOWN;
                // a few requests for floors that do not exist
                if (cmd == ecs_pkg::CMD_TICK || $urandom_range(0, 9) == 0)
                    flr = FLOOR_W'($urandom_range(0, 7));
                else
                    flr = FLOOR_W'($urandom_range(0, NUM_FLOORS - 1));
                issue_request(cmd, flr, 1'b0, none);
                if (cmd == ecs_pkg::CMD_TICK || flr < NUM_FLOORS) counted++;
            end
        end

        // drain: let the last reports arrive, then a few quiet cycles
        start <= 1'b0;
        for (int n = 0; n < 100 && pending_reports.size() != 0; n++) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            if (fault_count < REPORT_MAX)
                $display("%0d reports never arrived", pending_reports.size());
            fault_count += pending_reports.size();
        end

        if (fault_count == 0) begin
            $display("elevator_call_scheduler_core verification clean");
        end else begin
            $display("elevator_call_scheduler_core verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ecs_pkg.sv
rtl/ecs_ctrl.sv
rtl/ecs_datapath.sv
rtl/elevator_call_scheduler_core.sv
tb/tb_elevator_call_scheduler_core.sv
